FILE: rtl/sbtf_pkg.sv
package sbtf_pkg;

    // field widths of one input word and one result word
    localparam int SAMPLE_W = 10;
    localparam int BYTE_W   = 8;
    localparam int DROP_W   = 2;
    localparam int LEVEL_W  = 5;

    // operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR_LO,
        ST_WR_HI,
        ST_RD,
        ST_FIN_PUSH,
        ST_FIN_POP
    } sbtf_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic wr_lo;
        logic wr_hi;
        logic rd;
        logic fin_push;
        logic fin_pop;
    } sbtf_cmd_t;

endpackage

FILE: rtl/sbtf_ram.sv
module sbtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/sbtf_ctrl.sv
module sbtf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                operation,
    output logic                busy,
    output sbtf_pkg::sbtf_cmd_t cmd
);

    sbtf_pkg::sbtf_state_t state_reg;
    sbtf_pkg::sbtf_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbtf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sbtf_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (operation == sbtf_pkg::OP_POP)
                    begin
                        state_next = sbtf_pkg::ST_RD;
                    end
                    else
                    begin
                        state_next = sbtf_pkg::ST_WR_LO;
                    end
                end
            end
            sbtf_pkg::ST_WR_LO:    state_next = sbtf_pkg::ST_WR_HI;
            sbtf_pkg::ST_WR_HI:    state_next = sbtf_pkg::ST_FIN_PUSH;
            sbtf_pkg::ST_RD:       state_next = sbtf_pkg::ST_FIN_POP;
            sbtf_pkg::ST_FIN_PUSH: state_next = sbtf_pkg::ST_IDLE;
            sbtf_pkg::ST_FIN_POP:  state_next = sbtf_pkg::ST_IDLE;
            default:               state_next = sbtf_pkg::ST_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            sbtf_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            sbtf_pkg::ST_WR_LO:    cmd.wr_lo    = 1'b1;
            sbtf_pkg::ST_WR_HI:    cmd.wr_hi    = 1'b1;
            sbtf_pkg::ST_RD:       cmd.rd       = 1'b1;
            sbtf_pkg::ST_FIN_PUSH: cmd.fin_push = 1'b1;
            sbtf_pkg::ST_FIN_POP:  cmd.fin_pop  = 1'b1;
            default:               busy         = 1'b1;
        endcase
    end

endmodule

FILE: rtl/sbtf_dp.sv
module sbtf_dp #(
    parameter int DEPTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sbtf_pkg::sbtf_cmd_t           cmd,
    input  logic [sbtf_pkg::SAMPLE_W-1:0] sample,
    output logic                          done,
    output logic                          tx_valid,
    output logic [sbtf_pkg::BYTE_W-1:0]   tx_byte,
    output logic [sbtf_pkg::DROP_W-1:0]   dropped,
    output logic [sbtf_pkg::LEVEL_W-1:0]  fill_level
);

    localparam int PW = $clog2(DEPTH);
    localparam int FW = (PW + 1 > sbtf_pkg::LEVEL_W) ? PW + 1 : sbtf_pkg::LEVEL_W;
    localparam logic [PW-1:0] PTR_LAST  = PW'(DEPTH - 1);
    localparam logic [FW-1:0] DEPTH_FW  = FW'(DEPTH);

    logic [PW-1:0]                 wp_reg;
    logic [PW-1:0]                 rp_reg;
    logic [PW-1:0]                 wp_inc;
    logic [PW-1:0]                 rp_inc;
    logic                          full;
    logic                          empty;
    logic [FW-1:0]                 fill;
    logic [sbtf_pkg::SAMPLE_W-1:0] sample_reg;
    logic [sbtf_pkg::DROP_W-1:0]   lost_reg;
    logic                          pop_ok_reg;
    logic                          we;
    logic [sbtf_pkg::BYTE_W-1:0]   wdata;
    logic [sbtf_pkg::BYTE_W-1:0]   rdata;
    logic                          done_reg;
    logic                          tx_valid_reg;
    logic [sbtf_pkg::BYTE_W-1:0]   tx_byte_reg;
    logic [sbtf_pkg::DROP_W-1:0]   dropped_reg;
    logic [sbtf_pkg::LEVEL_W-1:0]  fill_reg;

    // pointer increment with wrap at the ring size
    assign wp_inc = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
    assign rp_inc = (rp_reg == PTR_LAST) ? '0 : rp_reg + 1'b1;
    assign full   = (wp_inc == rp_reg);
    assign empty  = (wp_reg == rp_reg);

    // bytes held, write minus read modulo ring size
    always_comb
    begin
        fill = FW'(wp_reg) - FW'(rp_reg);
        if (wp_reg < rp_reg)
        begin
            fill = fill + DEPTH_FW;
        end
    end

    // byte written this cycle: low byte, then high bits of the sample
    assign we    = cmd.wr_lo | cmd.wr_hi;
    assign wdata = cmd.wr_lo ? sample_reg[sbtf_pkg::BYTE_W-1:0]
                 : sbtf_pkg::BYTE_W'(sample_reg[sbtf_pkg::SAMPLE_W-1:sbtf_pkg::BYTE_W]);

    sbtf_ram #(
        .WIDTH (sbtf_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (wp_reg),
        .wdata (wdata),
        .raddr (rp_reg),
        .rdata (rdata)
    );

    // ring pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else if (we)
        begin
            wp_reg <= wp_inc;
            if (full)
            begin
                rp_reg <= rp_inc;
            end
        end
        else if (cmd.rd && !empty)
        begin
            rp_reg <= rp_inc;
        end
    end

    // per-word working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample;
            lost_reg   <= '0;
        end
        else if (we && full)
        begin
            lost_reg <= lost_reg + 1'b1;
        end
        if (cmd.rd)
        begin
            pop_ok_reg <= !empty;
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.fin_push | cmd.fin_pop;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.fin_push)
        begin
            tx_valid_reg <= 1'b0;
            tx_byte_reg  <= '0;
            dropped_reg  <= lost_reg;
            fill_reg     <= fill[sbtf_pkg::LEVEL_W-1:0];
        end
        else if (cmd.fin_pop)
        begin
            tx_valid_reg <= pop_ok_reg;
            tx_byte_reg  <= pop_ok_reg ? rdata : '0;
            dropped_reg  <= '0;
            fill_reg     <= fill[sbtf_pkg::LEVEL_W-1:0];
        end
    end

    assign done       = done_reg;
    assign tx_valid   = tx_valid_reg;
    assign tx_byte    = tx_byte_reg;
    assign dropped    = dropped_reg;
    assign fill_level = fill_reg;

    // a delivered byte never comes with dropped bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && tx_valid_reg |-> dropped_reg == '0)
        else $error("pop result reports dropped bytes");

    // result strobe lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");

    // high byte write always follows the low byte write
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_lo |=> cmd.wr_hi)
        else $error("high byte write missing after low byte");

    // ring never holds a full ring size of bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        fill < DEPTH_FW)
        else $error("ring fill out of range");

endmodule

FILE: rtl/sample_byte_tx_fifo_unit.sv
// Byte transmit ring buffer with overwrite of the oldest byte. Pulse start
// while busy is low to issue a word: operation 0 pushes the 10-bit sample as
// a low byte then a high byte, dropping the oldest byte before a write that
// finds the ring full; operation 1 pops the oldest byte (tx_valid low when the
// ring is empty). Every word gives exactly one result, shown for one cycle
// with done high; the receiver cannot stall it and must take it then. A push
// steps through WR_LO, WR_HI, FIN_PUSH and a pop through RD, FIN_POP before the
// next accept, set by the two byte writes and the registered read of the single
// byte memory. The ring holds at most DEPTH-1 bytes; fill_level reports the low 5 bits of the count.
module sample_byte_tx_fifo_unit #(
    parameter int DEPTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          operation,
    input  logic [sbtf_pkg::SAMPLE_W-1:0] sample,
    output logic                          done,
    output logic                          tx_valid,
    output logic [sbtf_pkg::BYTE_W-1:0]   tx_byte,
    output logic [sbtf_pkg::DROP_W-1:0]   dropped,
    output logic [sbtf_pkg::LEVEL_W-1:0]  fill_level
);

    sbtf_pkg::sbtf_cmd_t cmd;

    // sequencer
    sbtf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .busy      (busy),
        .cmd       (cmd)
    );

    // ring, pointers and result registers
    sbtf_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sample     (sample),
        .done       (done),
        .tx_valid   (tx_valid),
        .tx_byte    (tx_byte),
        .dropped    (dropped),
        .fill_level (fill_level)
    );

endmodule
